FILE: rtl/core/irc_tok_pkg.sv
// Shared types and constants of the IRC line tokenizer.
package irc_tok_pkg;

	// Token limit per line; the count saturates here and raises overflow.
	localparam logic [5:0] MAX_TOKENS = 6'd32;

	// Field widths
	localparam int unsigned CH_W    = 8;
	localparam int unsigned IDX_W   = 5;
	localparam int unsigned COUNT_W = 6;

	// Byte codes the parser reacts to
	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CH_W-1:0] PRINT_LO = 8'h20;
	localparam logic [CH_W-1:0] PRINT_HI = 8'h7E;

	// Output stream packing
	localparam int unsigned OUT_TDATA_W = 24;
	localparam int unsigned OUT_TUSER_W = 3;

	// Result of one byte, as handed from the parser to the output register.
	typedef struct packed {
		logic [CH_W-1:0]    data;
		logic               keep;
		logic               opens_token;
		logic               closes_token;
		logic [IDX_W-1:0]   token_index;
		logic               line_done;
		logic [COUNT_W-1:0] token_total;
		logic               overflow;
	} res_t;

endpackage

FILE: rtl/core/irc_tok_in_reg.sv
// Input register stage of the IRC line tokenizer.
module irc_tok_in_reg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [irc_tok_pkg::CH_W-1:0]    in_ch,
	input  logic                            advance,
	output logic                            valid_s1,
	output logic [irc_tok_pkg::CH_W-1:0]    ch_s1
);

	// The stage takes a new beat when it is empty or its beat moves on.
	assign in_ready = !valid_s1 || advance;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Byte payload, loaded on an accepted beat.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1 <= in_ch;
		end
	end

endmodule

FILE: rtl/core/irc_tok_core.sv
// Line parser of the IRC line tokenizer: phase state and per-byte decision logic.
module irc_tok_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [irc_tok_pkg::CH_W-1:0]  ch,
	output irc_tok_pkg::res_t             res
);

	typedef enum logic [2:0] {
		PH_SKIP  = 3'd0,
		PH_WORD  = 3'd1,
		PH_COLON = 3'd2,
		PH_TRAIL = 3'd3,
		PH_DROP  = 3'd4
	} phase_t;

	localparam logic [irc_tok_pkg::COUNT_W-1:0] LAST_IDX = irc_tok_pkg::MAX_TOKENS - 6'd1;

	phase_t                               phase_q, phase_n;
	logic [irc_tok_pkg::COUNT_W-1:0]      count_q, count_n;
	logic [irc_tok_pkg::CH_W-1:0]         delim_q, delim_n;
	logic                                 ovf_q, ovf_n;
	logic                                 keep, opens, closes, done;
	logic                                 printable, is_delim;
	logic [irc_tok_pkg::COUNT_W-1:0]      idx_full;

	assign printable = (ch >= irc_tok_pkg::PRINT_LO) && (ch <= irc_tok_pkg::PRINT_HI);
	assign is_delim  = (delim_q != irc_tok_pkg::CH_NUL) && (ch == delim_q);

	// Decide the flags for this byte and the state it leaves behind.
	always_comb begin
		phase_n = phase_q;
		count_n = count_q;
		delim_n = delim_q;
		ovf_n   = ovf_q;
		keep    = 1'b0;
		opens   = 1'b0;
		closes  = 1'b0;
		done    = 1'b0;
		if (ch == irc_tok_pkg::CH_NUL) begin
			closes = (phase_q == PH_WORD) || (phase_q == PH_COLON) || (phase_q == PH_TRAIL);
			done   = 1'b1;
		end else begin
			unique case (phase_q)
				PH_WORD: begin
					if (ch == irc_tok_pkg::CH_SPACE) begin
						closes  = 1'b1;
						phase_n = PH_SKIP;
					end else begin
						keep = 1'b1;
					end
				end
				PH_COLON: begin
					phase_n = PH_TRAIL;
					if (!printable) begin
						// A non-printable byte after the colon becomes the closer if none is set yet.
						if (delim_q == irc_tok_pkg::CH_NUL) begin
							delim_n = ch;
						end
					end else if (is_delim) begin
						closes  = 1'b1;
						phase_n = PH_SKIP;
					end else begin
						keep = 1'b1;
					end
				end
				PH_TRAIL: begin
					if (is_delim) begin
						closes  = 1'b1;
						phase_n = (delim_q == irc_tok_pkg::CH_SPACE) ? PH_SKIP : PH_DROP;
					end else begin
						keep = 1'b1;
					end
				end
				PH_DROP: begin
					if (ch == irc_tok_pkg::CH_SPACE) begin
						phase_n = PH_SKIP;
					end
				end
				default: begin
					// Skipping spaces, and any phase code with no meaning.
					phase_n = PH_SKIP;
					if (ch != irc_tok_pkg::CH_SPACE) begin
						opens = 1'b1;
						if (count_q >= irc_tok_pkg::MAX_TOKENS) begin
							count_n = irc_tok_pkg::MAX_TOKENS;
							ovf_n   = 1'b1;
						end else begin
							count_n = count_q + 6'd1;
						end
						if (ch == irc_tok_pkg::CH_COLON) begin
							// Only the prefix token closes a trailing part at a space.
							delim_n = (count_n == 6'd1 && !ovf_n) ? irc_tok_pkg::CH_SPACE
							                                      : irc_tok_pkg::CH_NUL;
							phase_n = PH_COLON;
						end else begin
							keep    = 1'b1;
							phase_n = PH_WORD;
						end
					end
				end
			endcase
		end
	end

	// Index of the current token, clamped to the last allowed one.
	always_comb begin
		idx_full = (count_n == 6'd0) ? 6'd0 : count_n - 6'd1;
		if (idx_full > LAST_IDX) begin
			idx_full = LAST_IDX;
		end
	end

	// Result of the byte; tokens past the limit are muted.
	always_comb begin
		res.data         = ch;
		res.keep         = keep && !ovf_n;
		res.opens_token  = opens && !ovf_n;
		res.closes_token = closes && !ovf_n;
		res.token_index  = idx_full[irc_tok_pkg::IDX_W-1:0];
		res.line_done    = done;
		res.token_total  = count_n;
		res.overflow     = ovf_n;
	end

	// Parser state; the end-of-line byte returns it to its start values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			count_q <= '0;
			delim_q <= irc_tok_pkg::CH_NUL;
			ovf_q   <= 1'b0;
		end else if (step) begin
			if (done) begin
				phase_q <= PH_SKIP;
				count_q <= '0;
				delim_q <= irc_tok_pkg::CH_NUL;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				count_q <= count_n;
				delim_q <= delim_n;
				ovf_q   <= ovf_n;
			end
		end
	end

endmodule

FILE: rtl/core/irc_line_tokenizer.sv
// Top level of the IRC line tokenizer: input stage, parser and output register.
//
//  Channel   Dir  Beat contents
//  s_axis    in   tdata[7:0] = ch (0 ends the line)
//  m_axis    out  tdata = data, token_index, token_total, overflow;
//                 tuser = keep, opens_token, closes_token; tlast = line_done
//
// One input beat yields one output beat; a beat can be taken every cycle unless
// m_axis stalls. A byte passes the input register, then the parser logic into
// the output register. The phase, count and delimiter registers are updated as
// a byte moves into the output register, so each byte sees the state left by
// the previous one. Reset clears the parser to the start of a line and empties
// both stages. A stall on m_axis holds the output beat and backs up into s_axis.
module irc_line_tokenizer (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [7:0] ch
	input  logic [irc_tok_pkg::CH_W-1:0]           s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [7:0] data, [12:8] token_index, [18:13] token_total, [19] overflow, [23:20] zero
	output logic [irc_tok_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// [0] keep, [1] opens_token, [2] closes_token
	output logic [irc_tok_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
	output logic                                   m_axis_tlast
);

	logic                            advance;
	logic                            valid_s1;
	logic [irc_tok_pkg::CH_W-1:0]    ch_s1;
	irc_tok_pkg::res_t               res;
	irc_tok_pkg::res_t               res_s2;
	logic                            valid_s2;

	// The output register moves on when it is empty or its beat is taken.
	assign advance = !valid_s2 || m_axis_tready;

	irc_tok_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_ch    (s_axis_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.ch_s1    (ch_s1)
	);

	irc_tok_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance && valid_s1),
		.ch     (ch_s1),
		.res    (res)
	);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

	// Pack the result onto the output stream.
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, res_s2.overflow, res_s2.token_total,
	                        res_s2.token_index, res_s2.data};
	assign m_axis_tuser  = {res_s2.closes_token, res_s2.opens_token, res_s2.keep};
	assign m_axis_tlast  = res_s2.line_done;

endmodule

FILE: rtl/core/irc_tok_checker.sv
// Port-level checks of the IRC line tokenizer, bound to its top level.
module irc_tok_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 m_axis_tvalid,
	input logic                                 m_axis_tready,
	input logic [irc_tok_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic [irc_tok_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
	input logic                                 m_axis_tlast
);

	// A stalled output beat holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// A kept byte belongs to a token that has been counted.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[18:13] != 6'd0)
		else $error("kept byte with no token counted");

	// Overflow only ever shows with the count at its limit, and mutes the flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[19] |->
			m_axis_tdata[18:13] == irc_tok_pkg::MAX_TOKENS && m_axis_tuser == '0)
		else $error("overflow beat with wrong count or unmuted flags");

	// A byte that opens a token never closes one or ends the line.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[2] && !m_axis_tlast)
		else $error("token opened and closed on the same byte");

endmodule

bind irc_line_tokenizer irc_tok_checker u_irc_tok_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
